// ===== sv/delta_bitstream_audio_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// delta_bitstream_audio_decoder_macros
// assertion macros for the decoder output stage, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef DELTA_BITSTREAM_AUDIO_DECODER_MACROS_SVH
`define DELTA_BITSTREAM_AUDIO_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, expects clk and rst_n in scope
`define DBAD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dbad assertion failed");

// next-cycle implication, expects clk and rst_n in scope
`define DBAD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dbad assertion failed");

`else

`define DBAD_ASSERT_IMP(lbl, ante, cons)
`define DBAD_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== sv/dbad_pkg.sv =====
// ----------------------------------------------------------------------------
// dbad_pkg
// shared widths, register indexes and step/result structs of the decoder
// ----------------------------------------------------------------------------
`default_nettype none

package dbad_pkg;

    localparam int BYTE_W     = 8;
    localparam int SAMPLE_W   = 16;
    localparam int REP_W      = 8;
    localparam int LEVEL_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MODE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_SAMPS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_SAMPS  = 3'd4;

    localparam logic [CFG_DATA_W-1:0] UNIT_SAMPS_RST = 16'd512;

    // one serial step: a data bit, or the close of the byte
    typedef struct packed {
        logic valid;
        logic bval;
        logic unit_start;
        logic final_unit;
        logic unit_end;
        logic close;
    } step_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                channel;
        logic [REP_W-1:0]    repeat_res;
        logic                unit_done;
        logic                error;
    } res_t;

    // decoder to output stage
    typedef struct packed {
        logic step_valid;
        logic close;
        logic res_valid;
        res_t res;
    } emit_t;

endpackage

`default_nettype wire

// ===== sv/dbad_byte_if.sv =====
// ----------------------------------------------------------------------------
// dbad_byte_if
// input channel: one packed byte of a unit per item
// ----------------------------------------------------------------------------
`default_nettype none

interface dbad_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       unit_start;
    logic       unit_end;
    logic       final_unit;

    modport source (output valid, output data_byte, output unit_start, output unit_end,
                    output final_unit, input ready);
    modport sink (input valid, input data_byte, input unit_start, input unit_end,
                  input final_unit, output ready);
endinterface

`default_nettype wire

// ===== sv/dbad_res_if.sv =====
// ----------------------------------------------------------------------------
// dbad_res_if
// result channel: one decoded sample, run or status per item
// ----------------------------------------------------------------------------
`default_nettype none

interface dbad_res_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               channel;
    logic [7:0]         repeat_res;
    logic               unit_done;
    logic               error;
    logic               last;

    modport source (output valid, output sample, output channel, output repeat_res,
                    output unit_done, output error, output last, input ready);
    modport sink (input valid, input sample, input channel, input repeat_res,
                  input unit_done, input error, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/dbad_serializer.sv =====
// ----------------------------------------------------------------------------
// dbad_serializer
// shifts an accepted byte out lsb first, then issues one close step
// ----------------------------------------------------------------------------
`default_nettype none

module dbad_serializer
    import dbad_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    dbad_byte_if.sink   in_ch,
    input  wire         adv,
    output step_t       step
);

    logic              busy_reg, busy_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [BYTE_W-1:0] shift_reg;
    logic              ustart_reg;
    logic              uend_reg;
    logic              final_reg;
    logic              closing;
    logic              take;

    assign closing = busy_reg && (cnt_reg == 4'(BYTE_W));
    // next byte may enter on the close step
    assign in_ch.ready = !busy_reg || (closing && adv);
    assign take = in_ch.valid && in_ch.ready;

    always_comb
    begin
        step.valid      = busy_reg;
        step.bval       = shift_reg[0];
        step.unit_start = ustart_reg && (cnt_reg == 4'd0);
        step.final_unit = final_reg;
        step.unit_end   = uend_reg;
        step.close      = closing;
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (take)
        begin
            busy_next = 1'b1;
            cnt_next  = 4'd0;
        end
        else if (busy_reg && adv)
        begin
            if (closing)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            shift_reg  <= in_ch.data_byte;
            ustart_reg <= in_ch.unit_start;
            uend_reg   <= in_ch.unit_end;
            final_reg  <= in_ch.final_unit;
        end
        else if (busy_reg && adv && !closing)
        begin
            shift_reg <= {1'b0, shift_reg[BYTE_W-1:1]};
        end
    end

endmodule

`default_nettype wire

// ===== sv/dbad_code_dec.sv =====
// ----------------------------------------------------------------------------
// dbad_code_dec
// bit collector, code decoder, predictors and unit sample count
// ----------------------------------------------------------------------------
`default_nettype none

module dbad_code_dec
    import dbad_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  step_t                 step,
    input  wire                   adv,
    input  wire [LEVEL_W-1:0]     level,
    input  wire                   zero_mode,
    input  wire                   stereo,
    input  wire [CFG_DATA_W-1:0]  unit_samps,
    input  wire [CFG_DATA_W-1:0]  last_samps,
    output emit_t                 em
);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_START  = 2'd1;
    localparam logic [1:0] PH_DECODE = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    localparam int BUF_W = 16;

    typedef struct packed {
        logic                done;
        logic [SAMPLE_W-1:0] np;
        logic [REP_W-1:0]    rep;
    } dec_t;

    function automatic dec_t decode_code(input logic [BUF_W-1:0] b,
                                         input logic [4:0] avail,
                                         input logic [SAMPLE_W-1:0] pred,
                                         input logic [LEVEL_W-1:0] lvl,
                                         input logic zmode);
        dec_t                r;
        logic [2:0]          typ;
        logic                hi_lvl;
        logic [3:0]          w;
        logic [3:0]          sh;
        logic [BUF_W-1:0]    v;
        logic [SAMPLE_W-1:0] mask;
        logic [SAMPLE_W-1:0] mag;
        logic [SAMPLE_W-1:0] d;
        logic [SAMPLE_W-1:0] delta_np;
        logic                sgn;
        logic [REP_W-1:0]    n8;
        r.done = 1'b0;
        r.np   = pred;
        r.rep  = 8'd1;
        typ    = b[2:0];
        hi_lvl = (lvl >= 3'd3);
        n8     = 8'd1;
        if (typ == 3'd7)
        begin
            w  = hi_lvl ? 4'd8 : 4'd8 - {1'b0, lvl};
            sh = hi_lvl ? 4'd9 : 4'd9 + {1'b0, lvl};
            v  = b >> 4;
        end
        else
        begin
            w  = hi_lvl ? 4'd3 + {1'b0, lvl} : 4'd5 - {1'b0, lvl};
            sh = hi_lvl ? 4'd1 + {1'b0, typ} : 4'd2 + {1'b0, typ} + {1'b0, lvl};
            v  = b >> 3;
        end
        // signed magnitude: top bit of the field is the sign
        mask     = (16'd1 << (w - 4'd1)) - 16'd1;
        mag      = v & mask;
        sgn      = v[w - 4'd1];
        d        = mag << sh;
        delta_np = sgn ? pred - d : pred + d;
        if (avail >= 5'd3)
        begin
            if (typ == 3'd0)
            begin
                if (!zmode)
                    r.done = 1'b1;
                else if (avail >= 5'd4)
                begin
                    if (!b[3])
                        r.done = 1'b1;
                    else if (avail >= 5'd6)
                    begin
                        if (b[5:4] == 2'b11)
                        begin
                            if (avail >= 5'd14)
                            begin
                                n8     = b[13:6];
                                r.done = 1'b1;
                            end
                        end
                        else
                        begin
                            n8     = {6'd0, b[5:4]};
                            r.done = 1'b1;
                        end
                        // run of zero length counts as one sample
                        r.rep = (n8 == 8'd0) ? 8'd1 : n8;
                    end
                end
            end
            else if (typ == 3'd7)
            begin
                if (avail >= 5'd4)
                begin
                    if (b[3])
                    begin
                        r.np   = '0;
                        r.done = 1'b1;
                    end
                    else if (avail >= 5'd4 + {1'b0, w})
                    begin
                        r.np   = delta_np;
                        r.done = 1'b1;
                    end
                end
            end
            else if (avail >= 5'd3 + {1'b0, w})
            begin
                r.np   = delta_np;
                r.done = 1'b1;
            end
        end
        return r;
    endfunction

    logic [BUF_W-1:0]       bits_reg, bits_next;
    logic [4:0]             cnt_reg, cnt_next;
    logic [SAMPLE_W-1:0]    pred_reg [2];
    logic [SAMPLE_W-1:0]    pred_next [2];
    logic                   ch_reg, ch_next;
    logic [COUNT_WIDTH-1:0] left_reg, left_next;
    logic [1:0]             ph_reg, ph_next;

    logic [BUF_W-1:0]       nb;
    logic [4:0]             nc;
    logic [BUF_W-1:0]       dec_bits;
    logic [4:0]             dec_avail;
    dec_t                   dec;
    logic                   code_hit;
    logic                   at_end;
    logic [REP_W-1:0]       run;
    logic                   active;

    always_comb
    begin
        bits_next    = bits_reg;
        cnt_next     = cnt_reg;
        pred_next[0] = pred_reg[0];
        pred_next[1] = pred_reg[1];
        ch_next      = ch_reg;
        left_next    = left_reg;
        ph_next      = ph_reg;
        code_hit     = 1'b0;
        at_end       = 1'b0;
        run          = '0;
        em.step_valid = step.valid;
        em.close      = step.close;
        em.res_valid  = 1'b0;
        em.res        = '0;

        if (step.unit_start)
        begin
            bits_next    = '0;
            cnt_next     = '0;
            pred_next[0] = '0;
            pred_next[1] = '0;
            ch_next      = 1'b0;
            left_next    = step.final_unit ? COUNT_WIDTH'(last_samps)
                                           : COUNT_WIDTH'(unit_samps);
            ph_next      = PH_START;
        end

        active = (ph_next == PH_START) || (ph_next == PH_DECODE);
        nb = bits_next | (BUF_W'(step.bval) << cnt_next[3:0]);
        nc = cnt_next + 5'd1;

        // end of data decodes the pending bits as if zero padded
        dec_bits  = step.close ? bits_next : nb;
        dec_avail = step.close ? 5'd24 : nc;
        dec = decode_code(dec_bits, dec_avail, pred_next[ch_next], level, zero_mode);

        if (!step.close)
        begin
            if (ph_next == PH_START)
            begin
                if (nc == 5'd16)
                begin
                    pred_next[ch_next] = nb;
                    bits_next = '0;
                    cnt_next  = '0;
                    if (stereo && !ch_next)
                        ch_next = 1'b1;
                    else
                    begin
                        ch_next = 1'b0;
                        ph_next = (left_next != '0) ? PH_DECODE : PH_DONE;
                    end
                end
                else
                begin
                    bits_next = nb;
                    cnt_next  = nc;
                end
            end
            else if (ph_next == PH_DECODE)
            begin
                if (dec.done)
                begin
                    code_hit  = 1'b1;
                    bits_next = '0;
                    cnt_next  = '0;
                end
                else
                begin
                    bits_next = nb;
                    cnt_next  = nc;
                end
            end
        end
        else if (step.unit_end && active)
        begin
            if ((ph_next == PH_DECODE) && (cnt_next != '0))
            begin
                code_hit = 1'b1;
                at_end   = 1'b1;
            end
            else if (left_next != '0)
            begin
                // data ran out: status-only item
                em.res_valid = 1'b1;
                em.res.error = 1'b1;
            end
            ph_next   = PH_DONE;
            bits_next = '0;
            cnt_next  = '0;
        end

        if (code_hit)
        begin
            // clip the run to the samples left in the unit
            run = (COUNT_WIDTH'(dec.rep) < left_next) ? dec.rep : left_next[REP_W-1:0];
            pred_next[ch_next] = dec.np;
            left_next = left_next - COUNT_WIDTH'(run);
            em.res_valid      = 1'b1;
            em.res.sample     = dec.np;
            em.res.channel    = ch_next;
            em.res.repeat_res = run;
            em.res.unit_done  = (left_next == '0);
            em.res.error      = at_end && (left_next != '0);
            if (stereo)
                ch_next = !ch_next;
            if (left_next == '0)
                ph_next = PH_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg    <= '0;
            cnt_reg     <= '0;
            pred_reg[0] <= '0;
            pred_reg[1] <= '0;
            ch_reg      <= 1'b0;
            left_reg    <= '0;
            ph_reg      <= PH_IDLE;
        end
        else if (adv)
        begin
            bits_reg    <= bits_next;
            cnt_reg     <= cnt_next;
            pred_reg[0] <= pred_next[0];
            pred_reg[1] <= pred_next[1];
            ch_reg      <= ch_next;
            left_reg    <= left_next;
            ph_reg      <= ph_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/dbad_out_stage.sv =====
// ----------------------------------------------------------------------------
// dbad_out_stage
// hold slot plus output register; marks the final item of each byte
// ----------------------------------------------------------------------------
`default_nettype none
`include "delta_bitstream_audio_decoder_macros.svh"

module dbad_out_stage
    import dbad_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    input  emit_t        em,
    output logic         adv,
    dbad_res_if.source   out_ch
);

    logic hold_valid_reg, hold_valid_next;
    logic hold_last_reg, hold_last_next;
    res_t hold_res_reg;
    logic out_valid_reg, out_valid_next;
    res_t out_res_reg;
    logic out_last_reg;

    logic out_free;
    logic need;
    logic load_out;
    logic out_last_v;

    // an item is held back until the next item or the close shows whether it is the last
    always_comb
    begin
        out_free   = !out_valid_reg || out_ch.ready;
        need       = em.res_valid || em.close;
        adv        = em.step_valid && (!need || !hold_valid_reg || out_free);
        load_out   = hold_valid_reg && out_free && (hold_last_reg || (adv && need));
        out_last_v = hold_last_reg || (em.close && !em.res_valid);

        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;

        hold_valid_next = hold_valid_reg;
        hold_last_next  = hold_last_reg;
        if (adv && em.res_valid)
        begin
            hold_valid_next = 1'b1;
            hold_last_next  = em.close;
        end
        else if (load_out)
        begin
            hold_valid_next = 1'b0;
            hold_last_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
            hold_last_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
            hold_last_reg  <= hold_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && em.res_valid)
            hold_res_reg <= em.res;
        if (load_out)
        begin
            out_res_reg  <= hold_res_reg;
            out_last_reg <= out_last_v;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.sample     = $signed(out_res_reg.sample);
    assign out_ch.channel    = out_res_reg.channel;
    assign out_ch.repeat_res = out_res_reg.repeat_res;
    assign out_ch.unit_done  = out_res_reg.unit_done;
    assign out_ch.error      = out_res_reg.error;
    assign out_ch.last       = out_last_reg;

    // a new item never lands on a full hold slot that cannot drain
    `DBAD_ASSERT_IMP(a_no_overwrite, adv && em.res_valid && hold_valid_reg, out_free)
    // last mark only on a held item
    `DBAD_ASSERT_IMP(a_last_held, hold_last_reg, hold_valid_reg)
    // a drained item shows up on the port
    `DBAD_ASSERT_NXT(a_out_loaded, load_out, out_valid_reg)

endmodule

`default_nettype wire

// ===== sv/delta_bitstream_audio_decoder.sv =====
// ----------------------------------------------------------------------------
// delta_bitstream_audio_decoder
// delta-coded audio unit decoder, bit serial, one packed byte per item
// ----------------------------------------------------------------------------
// usage
//   in_ch takes one packed byte per item, lsb first within the stream;
//   unit_start on the first byte restarts decoding, unit_end marks the
//   last byte, final_unit selects the last unit's sample count
//   out_ch gives one item per decoded code (sample plus repeat count),
//   or a status-only item (repeat_res 0, error 1) when data runs out;
//   last is set on the final item caused by an input byte
//   cfg_we/cfg_idx/cfg_data write the five setup registers, idle only
// timing
//   each byte walks through a shift register one bit per cycle while out_ch
//   does not stall, then one close step; the next byte is taken on the
//   close step
//   an item waits in the hold slot until the next item or the close
// reset and stall
//   reset clears all control state, predictors and the sample count; the
//   block waits for a byte with unit_start, no clearing pass is needed
//   when out_ch stalls, one item waits in the output register and one in
//   the hold slot; the bit engine then stops and in_ch drops ready
// ----------------------------------------------------------------------------
`default_nettype none

module delta_bitstream_audio_decoder
    import dbad_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    dbad_byte_if.sink             in_ch,
    dbad_res_if.source            out_ch,
    input  wire                   cfg_we,
    input  wire [CFG_IDX_W-1:0]   cfg_idx,
    input  wire [CFG_DATA_W-1:0]  cfg_data
);

    // setup registers
    logic [LEVEL_W-1:0]    level_reg;
    logic                  zero_mode_reg;
    logic                  stereo_reg;
    logic [CFG_DATA_W-1:0] unit_samps_reg;
    logic [CFG_DATA_W-1:0] last_samps_reg;

    // serial step from the byte shifter, handshake from the output stage
    step_t step;
    emit_t em;
    logic  adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg      <= '0;
            zero_mode_reg  <= 1'b0;
            stereo_reg     <= 1'b0;
            unit_samps_reg <= UNIT_SAMPS_RST;
            last_samps_reg <= UNIT_SAMPS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_LEVEL:      level_reg      <= cfg_data[LEVEL_W-1:0];
                CFG_ZERO_MODE:  zero_mode_reg  <= cfg_data[0];
                CFG_STEREO:     stereo_reg     <= cfg_data[0];
                CFG_UNIT_SAMPS: unit_samps_reg <= cfg_data;
                CFG_LAST_SAMPS: last_samps_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // byte to bit shifter
    dbad_serializer u_ser (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .adv   (adv),
        .step  (step)
    );

    // code decoding, predictors and sample count
    dbad_code_dec #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dec (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .adv        (adv),
        .level      (level_reg),
        .zero_mode  (zero_mode_reg),
        .stereo     (stereo_reg),
        .unit_samps (unit_samps_reg),
        .last_samps (last_samps_reg),
        .em         (em)
    );

    // hold slot and output register, sets last per byte
    dbad_out_stage u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .em     (em),
        .adv    (adv),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire

// ===== verif/delta_bitstream_audio_decoder_checker.sv =====
// ----------------------------------------------------------------------------
// delta_bitstream_audio_decoder_checker
// watches the byte, result and setup ports of the decoder, predicts every
// result from the accepted bytes and compares it with what the block gives
// ----------------------------------------------------------------------------
module delta_bitstream_audio_decoder_checker
    import dbad_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    dbad_byte_if                  in_mon,
    dbad_res_if                   out_mon,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);

    localparam int REPORT_MAX = 10;

    typedef enum logic [1:0] {UNIT_WAIT, UNIT_HEADER, UNIT_CODES, UNIT_OVER} unit_phase_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                channel;
        logic [REP_W-1:0]    reps;
        logic                done;
        logic                err;
        logic                last;
    } sample_item_t;

    // setup registers
    logic [LEVEL_W-1:0]    lvl;
    logic                  zmode;
    logic                  stereo_on;
    logic [15:0]           unit_len;
    logic [15:0]           final_len;

    // decoder state
    logic [23:0]           bits;
    int                    cnt;
    logic [SAMPLE_W-1:0]   pred [2];
    logic                  chan;
    logic [15:0]           left;
    unit_phase_t           ph;

    sample_item_t          sample_q [$];
    int                    errs = 0;

    function automatic logic [15:0] add_delta(input logic [15:0] prev, input int unsigned v,
                                              input int w, input int sh);
        int unsigned mag_shifted;
        mag_shifted = (v & ((1 << (w - 1)) - 1)) << sh;
        return ((v >> (w - 1)) & 1) ? prev - mag_shifted[15:0] : prev + mag_shifted[15:0];
    endfunction

    // 1 when bits holds a whole code within avail bits
    function automatic bit try_code(input logic [23:0] code_bits, input int avail,
                                    input logic [15:0] prev, output logic [15:0] nv,
                                    output int run);
        int unsigned raw;
        int          kind, w, sh, n;
        raw  = code_bits;
        nv   = prev;
        run  = 1;
        if (avail < 3)
            return 1'b0;
        kind = raw & 7;
        if (kind == 0)
        begin
            if (!zmode)
                return 1'b1;
            if (avail < 4)
                return 1'b0;
            if (!code_bits[3])
                return 1'b1;
            if (avail < 6)
                return 1'b0;
            n = (raw >> 4) & 3;
            if (n == 3)
            begin
                if (avail < 14)
                    return 1'b0;
                n = (raw >> 6) & 8'hFF;
            end
            run = (n == 0) ? 1 : n;
            return 1'b1;
        end
        if (kind == 7)
        begin
            if (avail < 4)
                return 1'b0;
            if (code_bits[3])
            begin
                nv = '0;
                return 1'b1;
            end
            w  = (lvl >= 3) ? 8 : 8 - int'(lvl);
            sh = (lvl >= 3) ? 9 : 9 + int'(lvl);
            if (avail < 4 + w)
                return 1'b0;
            nv = add_delta(prev, (raw >> 4) & ((1 << w) - 1), w, sh);
            return 1'b1;
        end
        w  = (lvl >= 3) ? 3 + int'(lvl) : 5 - int'(lvl);
        sh = (lvl >= 3) ? 1 + kind : 2 + kind + int'(lvl);
        if (avail < 3 + w)
            return 1'b0;
        nv = add_delta(prev, (raw >> 3) & ((1 << w) - 1), w, sh);
        return 1'b1;
    endfunction

    function automatic void push_sample(input logic [15:0] nv, input int run, input bit at_end);
        sample_item_t it;
        int           r;
        r        = (run < int'(left)) ? run : int'(left);
        pred[chan] = nv;
        left     = left - r[15:0];
        it.sample  = nv;
        it.channel = chan;
        it.reps    = r[7:0];
        it.done    = (left == 0);
        it.err     = at_end && (left != 0);
        it.last    = 1'b0;
        sample_q   = {sample_q, it};
        if (stereo_on)
            chan = ~chan;
        if (left == 0)
            ph = UNIT_OVER;
    endfunction

    function automatic void decode_byte(input logic [7:0] d, input logic s, input logic e,
                                        input logic f);
        logic [15:0]  nv;
        int           run, n0, i;
        sample_item_t status;
        n0 = sample_q.size();
        if (s)
        begin
            bits    = '0;
            cnt     = 0;
            pred[0] = '0;
            pred[1] = '0;
            chan    = 1'b0;
            left    = f ? final_len : unit_len;
            ph      = UNIT_HEADER;
        end
        for (i = 0; i < 8; i++)
        begin
            if (ph != UNIT_HEADER && ph != UNIT_CODES)
                break;
            bits[cnt] = d[i];
            cnt++;
            if (ph == UNIT_HEADER)
            begin
                if (cnt == 16)
                begin
                    pred[chan] = bits[15:0];
                    bits = '0;
                    cnt  = 0;
                    if (stereo_on && !chan)
                    begin
                        chan = 1'b1;
                    end
                    else
                    begin
                        chan = 1'b0;
                        ph   = (left != 0) ? UNIT_CODES : UNIT_OVER;
                    end
                end
            end
            else if (try_code(bits, cnt, pred[chan], nv, run))
            begin
                bits = '0;
                cnt  = 0;
                push_sample(nv, run, 1'b0);
            end
        end
        // close of the unit: flush a partial code or flag missing data
        if (e && (ph == UNIT_HEADER || ph == UNIT_CODES))
        begin
            if (ph == UNIT_CODES && cnt > 0)
            begin
                void'(try_code(bits, 24, pred[chan], nv, run));
                push_sample(nv, run, 1'b1);
            end
            else if (left != 0)
            begin
                status     = '0;
                status.err = 1'b1;
                sample_q   = {sample_q, status};
            end
            ph   = UNIT_OVER;
            bits = '0;
            cnt  = 0;
        end
        if (sample_q.size() > n0)
            sample_q[sample_q.size() - 1].last = 1'b1;
    endfunction

    // compare one accepted result with the oldest prediction
    function automatic void check_result(input sample_item_t got);
        sample_item_t want;
        if (sample_q.size() == 0)
        begin
            errs++;
            if (errs <= REPORT_MAX)
                $display("unexpected result: sample %0d ch %0b rep %0d done %0b err %0b last %0b",
                         $signed(got.sample), got.channel, got.reps, got.done,
                         got.err, got.last);
            return;
        end
        want = sample_q.pop_front();
        if (got !== want)
        begin
            errs++;
            if (errs <= REPORT_MAX)
            begin
                $write("mismatch: expected sample %0d ch %0b rep %0d done %0b err %0b last %0b",
                       $signed(want.sample), want.channel, want.reps, want.done,
                       want.err, want.last);
                $display(", got sample %0d ch %0b rep %0d done %0b err %0b last %0b",
                         $signed(got.sample), got.channel, got.reps, got.done,
                         got.err, got.last);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sample_item_t got;
        if (!rst_n)
        begin
            lvl       = '0;
            zmode     = 1'b0;
            stereo_on = 1'b0;
            unit_len  = UNIT_SAMPS_RST;
            final_len = UNIT_SAMPS_RST;
            bits      = '0;
            cnt       = 0;
            pred[0]   = '0;
            pred[1]   = '0;
            chan      = 1'b0;
            left      = '0;
            ph        = UNIT_WAIT;
            sample_q.delete();
            pending    <= 0;
            fail_count <= errs;
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                got.sample  = out_mon.sample;
                got.channel = out_mon.channel;
                got.reps    = out_mon.repeat_res;
                got.done    = out_mon.unit_done;
                got.err     = out_mon.error;
                got.last    = out_mon.last;
                check_result(got);
            end
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_LEVEL:      lvl       = cfg_data[LEVEL_W-1:0];
                    CFG_ZERO_MODE:  zmode     = cfg_data[0];
                    CFG_STEREO:     stereo_on = cfg_data[0];
                    CFG_UNIT_SAMPS: unit_len  = cfg_data[15:0];
                    CFG_LAST_SAMPS: final_len = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (in_mon.valid && in_mon.ready)
                decode_byte(in_mon.data_byte, in_mon.unit_start, in_mon.unit_end,
                            in_mon.final_unit);
            pending    <= sample_q.size();
            fail_count <= errs;
        end
    end

endmodule

// ===== verif/delta_bitstream_audio_decoder_test.sv =====
// ----------------------------------------------------------------------------
// delta_bitstream_audio_decoder_test
// drives packed unit bytes into the decoder under changing setups and idling
// patterns; a checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module delta_bitstream_audio_decoder_test;
    import dbad_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 40;     // room for a byte to pass the bit engine
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PHASES = 8;      // one per compression level
    localparam int PHASE_ITEMS   = 45;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_id;
    int hold_ack;
    int hold_left;
    int cycles;
    int items;
    bit cur_stereo;

    dbad_byte_if in_if();
    dbad_res_if  out_if();

    delta_bitstream_audio_decoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_if),
        .out_ch   (out_if),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    delta_bitstream_audio_decoder_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mon     (in_if),
        .out_mon    (out_if),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 8 unit clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result side: random stalls, plus a long hold-off whenever hold_id moves
    initial
    begin
        out_if.ready = 1'b0;
        hold_ack     = 0;
        hold_left    = 0;
        forever
        begin
            @(posedge clk);
            if (hold_ack != hold_id)
            begin
                hold_ack  = hold_id;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_if.ready <= 1'b0;
            end
            else
            begin
                out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // watchdog on the whole run
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // offer one byte, with random idle cycles ahead of it, and wait until taken
    task automatic send_byte(input logic [7:0] d, input bit s, input bit e, input bit f);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid      <= 1'b1;
        in_if.data_byte  <= d;
        in_if.unit_start <= s;
        in_if.unit_end   <= e;
        in_if.final_unit <= f;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        items++;
    endtask

    // stop sending until every predicted result is out and the bit engine is empty
    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge clk);
    endtask

    // all five registers, only while the block is idle
    task automatic set_config(input int level, input int zm, input int st, input int spu,
                              input int lus);
        write_reg(CFG_LEVEL, level);
        write_reg(CFG_ZERO_MODE, zm);
        write_reg(CFG_STEREO, st);
        write_reg(CFG_UNIT_SAMPS, spu);
        write_reg(CFG_LAST_SAMPS, lus);
        cfg_we     <= 1'b0;
        cur_stereo  = st[0];
    endtask

    task automatic set_idling(input int tx, input int rx);
        tx_idle_pct  = tx;
        rx_idle_pct <= rx;
    endtask

    // one unit: start samples then n_data random bytes; noisy units may restart
    // in the middle, and a unit without close is cut off by the next start
    task automatic send_unit(input int n_data, input bit fin, input bit close, input bit noisy);
        int total;
        int k;
        bit restart;
        total = (cur_stereo ? 4 : 2) + n_data;
        for (k = 0; k < total; k++)
        begin
            restart = noisy && (k > 0) && ($urandom_range(99) < 4);
            send_byte(8'($urandom_range(255)), (k == 0) || restart,
                      close && (k == total - 1),
                      (k == 0) ? fin : bit'($urandom_range(1)));
        end
    endtask

    initial
    begin
        int p;
        int spu;
        int lus;
        int phase_base;

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = '0;
        cfg_data         = '0;
        in_if.valid      = 1'b0;
        in_if.data_byte  = '0;
        in_if.unit_start = 1'b0;
        in_if.unit_end   = 1'b0;
        in_if.final_unit = 1'b0;
        hold_id          = 0;
        items            = 0;
        cur_stereo       = 1'b0;
        tx_idle_pct      = 10;
        rx_idle_pct      = 74;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        set_idling(10, 74);

        // mono unit of 4 samples, the last one flushed from a partial code at the close
        set_config(0, 0, 0, 4, 2);
        send_byte(8'hFF, 1, 0, 0);
        send_byte(8'h7F, 0, 0, 0);
        send_byte(8'h00, 0, 0, 0);
        send_byte(8'hFF, 0, 1, 0);
        // final unit with its own count, runs out of data after one sample
        send_byte(8'h00, 1, 0, 1);
        send_byte(8'h80, 0, 0, 1);
        send_byte(8'h12, 0, 1, 1);
        // stray byte after the unit is over: no result
        send_byte(8'hA5, 0, 1, 1);
        drain();

        // empty unit gives nothing, then a unit that runs out inside its start sample
        set_config(1, 0, 0, 0, 3);
        send_byte(8'h34, 1, 0, 0);
        send_byte(8'h12, 0, 0, 0);
        send_byte(8'hAA, 0, 1, 0);
        send_byte(8'h01, 1, 1, 1);
        drain();

        // stereo with zero runs: a run of length zero, then a run of 200 clipped
        set_config(5, 1, 1, 3, 16'hFFFF);
        send_byte(8'h00, 1, 0, 0);
        send_byte(8'h80, 0, 0, 0);
        send_byte(8'hFF, 0, 0, 0);
        send_byte(8'h7F, 0, 0, 0);
        send_byte(8'h38, 0, 0, 0);
        send_byte(8'h00, 0, 0, 0);
        send_byte(8'h8E, 0, 0, 0);
        send_byte(8'h0C, 0, 1, 0);
        // largest final unit cut short in the middle of a long delta code
        send_byte(8'h11, 1, 0, 1);
        send_byte(8'h22, 0, 0, 1);
        send_byte(8'h33, 0, 0, 1);
        send_byte(8'h44, 0, 0, 1);
        send_byte(8'h47, 0, 1, 1);

        // ---- random part, one phase per compression level ----
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            if (p < 3)
                set_idling(10, 74);
            else if (p < 6)
                set_idling(74, 10);
            else
                set_idling(0, 0);

            // mostly short units so that completion is reached often
            case ($urandom_range(9))
                0:       spu = 16'hFFFF;
                1:       spu = 0;
                default: spu = $urandom_range(1, 40);
            endcase
            case ($urandom_range(3))
                0:       lus = 16'hFFFF;
                1:       lus = 0;
                default: lus = $urandom_range(1, 40);
            endcase
            if (p == 0)
                spu = 1;
            set_config(p, $urandom_range(1), $urandom_range(1), spu, lus);

            // long result hold-off while bytes keep coming, so the input backs up
            if (p == 6)
            begin
                hold_id <= hold_id + 1;
                send_unit(24, 0, 1, 0);
            end

            phase_base = items;
            while (items - phase_base < PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 10)
                    send_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)),
                              1'($urandom_range(1)));
                else
                    send_unit($urandom_range(0, 14), $urandom_range(99) < 25,
                              $urandom_range(99) < 92, 1);
            end
        end

        drain();
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== delta_bitstream_audio_decoder.f =====
+incdir+sv
sv/dbad_pkg.sv
sv/dbad_byte_if.sv
sv/dbad_res_if.sv
sv/dbad_serializer.sv
sv/dbad_code_dec.sv
sv/dbad_out_stage.sv
sv/delta_bitstream_audio_decoder.sv
verif/delta_bitstream_audio_decoder_checker.sv
verif/delta_bitstream_audio_decoder_test.sv
